### sv/fbs_pkg.sv
package fbs_pkg;

   localparam int DEFAULT_MAX_PAYLOAD_BYTES = 256;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_LOW_TONE_FREQ  = 3'd0,
      CSR_HIGH_TONE_FREQ = 3'd1,
      CSR_SYMBOL_TICKS   = 3'd2,
      CSR_PREAMBLE_TICKS = 3'd3,
      CSR_REPEAT_ENABLE  = 3'd4,
      CSR_PAYLOAD_LENGTH = 3'd5
   } fbs_csr_type;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_WRITE = 2'd1,
      OP_START = 2'd2,
      OP_STOP  = 2'd3
   } fbs_op_type;

   typedef struct packed {
      fbs_op_type  req_type;
      logic [7:0]  write_addr;
      logic [7:0]  write_data;
   } fbs_req_type;

   typedef struct packed {
      logic        tone_on;
      logic [15:0] tone_freq;
      logic        symbol_strobe;
      logic        tx_busy;
      logic        in_preamble_flag;
      logic [8:0]  byte_index;
      logic [2:0]  bit_position;
   } fbs_rsp_type;

endpackage

### sv/fsk_bit_serializer_with_preamble.sv
// Responses are registered in the output register. Throughput: one request per cycle
// unless the output is stalled; the payload buffer read for the next bit is issued in
// the same cycle the pointer updates, so ticks can arrive back to back.
// Reset: synchronous, active high; resets flags, counters, tone and config registers.
// The payload buffer is not cleared; unwritten entries read as unknown.
module fsk_bit_serializer_with_preamble import fbs_pkg::*; #(
   parameter int MAX_PAYLOAD_BYTES = DEFAULT_MAX_PAYLOAD_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  fbs_req_type           req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output fbs_rsp_type           rsp_payload,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1;

   // config
   logic [15:0] low_freq_ff, high_freq_ff, sym_ticks_ff, pre_ticks_ff;
   logic        repeat_ff;
   logic [8:0]  length_ff;

   // transmitter state
   logic        busy_ff, busy_in;
   logic        pre_ff, pre_in;
   logic [15:0] pre_left_ff, pre_left_in;
   logic        parity_ff, parity_in;
   logic [15:0] timer_ff, timer_in;
   logic [8:0]  byte_ptr_ff, byte_ptr_in;
   logic [2:0]  bit_ptr_ff, bit_ptr_in;
   logic        tone_on_ff, tone_on_in;
   logic [15:0] tone_freq_ff, tone_freq_in;

   // buffer
   logic [7:0]  payload_mem [MAX_PAYLOAD_BYTES];
   logic [7:0]  rd_data_ff;
   logic [7:0]  byte0_ff;
   logic        mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [31:0] waddr_ext, raddr_ext;

   // output register
   logic        rsp_valid_ff;
   fbs_rsp_type rsp_payload_ff, rsp_payload_in;

   logic        accept;
   logic        strobe;
   logic [15:0] period;
   logic [16:0] timer_inc;
   logic [8:0]  len_cap;
   logic        go_on;
   logic        do_send;
   logic [7:0]  cur_byte;
   logic        cur_bit;

   assign req_stall   = rsp_valid_ff & rsp_stall;
   assign accept      = req_valid & ~req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_freq_ff  <= '0;
         high_freq_ff <= '0;
         sym_ticks_ff <= 16'd1;
         pre_ticks_ff <= '0;
         repeat_ff    <= 1'b0;
         length_ff    <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_LOW_TONE_FREQ:  low_freq_ff  <= csr_wdata;
            CSR_HIGH_TONE_FREQ: high_freq_ff <= csr_wdata;
            CSR_SYMBOL_TICKS:   sym_ticks_ff <= csr_wdata;
            CSR_PREAMBLE_TICKS: pre_ticks_ff <= csr_wdata;
            CSR_REPEAT_ENABLE:  repeat_ff    <= csr_wdata[0];
            CSR_PAYLOAD_LENGTH: length_ff    <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   assign period    = (sym_ticks_ff == '0) ? 16'd1 : sym_ticks_ff;
   assign timer_inc = {1'b0, timer_ff} + 17'd1;
   assign len_cap   = ({23'd0, length_ff} > MAX_PAYLOAD_BYTES) ?
                      9'(MAX_PAYLOAD_BYTES) : length_ff;

   always_comb begin
      busy_in      = busy_ff;
      pre_in       = pre_ff;
      pre_left_in  = pre_left_ff;
      parity_in    = parity_ff;
      timer_in     = timer_ff;
      byte_ptr_in  = byte_ptr_ff;
      bit_ptr_in   = bit_ptr_ff;
      tone_on_in   = tone_on_ff;
      tone_freq_in = tone_freq_ff;
      strobe       = 1'b0;
      go_on        = 1'b0;
      do_send      = 1'b0;
      cur_byte     = '0;
      cur_bit      = 1'b0;
      mem_we       = 1'b0;
      if (accept) begin
         case (req_payload.req_type)
            OP_TICK: begin
               if (busy_ff) begin
                  if (pre_ff && pre_left_ff != '0)
                     pre_left_in = pre_left_ff - 16'd1;
                  if (timer_inc >= {1'b0, period}) begin
                     timer_in = '0;
                     go_on    = 1'b1;
                     if (pre_ff) begin
                        if (pre_left_in != '0) begin
                           tone_on_in   = 1'b1;
                           tone_freq_in = parity_ff ? high_freq_ff : low_freq_ff;
                           parity_in    = ~parity_ff;
                           strobe       = 1'b1;
                           go_on        = 1'b0;
                        end else begin
                           pre_in      = 1'b0;
                           byte_ptr_in = '0;
                           bit_ptr_in  = '0;
                        end
                     end
                     if (go_on) begin
                        if (byte_ptr_in >= len_cap) begin
                           if (!repeat_ff) begin
                              busy_in    = 1'b0;
                              pre_in     = 1'b0;
                              tone_on_in = 1'b0;
                           end else begin
                              byte_ptr_in = '0;
                              bit_ptr_in  = '0;
                              if (pre_ticks_ff != '0) begin
                                 pre_in       = 1'b1;
                                 pre_left_in  = pre_ticks_ff;
                                 tone_on_in   = 1'b1;
                                 tone_freq_in = high_freq_ff;
                                 parity_in    = 1'b0;
                                 strobe       = 1'b1;
                              end else if (len_cap == '0) begin
                                 tone_on_in = 1'b0;
                              end else begin
                                 do_send = 1'b1;
                              end
                           end
                        end else begin
                           do_send = 1'b1;
                        end
                     end
                     if (do_send) begin
                        // rd_data_ff holds the byte at the pointer before this request
                        cur_byte     = (byte_ptr_in == '0) ? byte0_ff : rd_data_ff;
                        cur_bit      = cur_byte[~bit_ptr_in];
                        tone_on_in   = 1'b1;
                        tone_freq_in = cur_bit ? high_freq_ff : low_freq_ff;
                        strobe       = 1'b1;
                        bit_ptr_in   = bit_ptr_in + 3'd1;
                        if (bit_ptr_in == '0)
                           byte_ptr_in = byte_ptr_in + 9'd1;
                     end
                  end else begin
                     timer_in = timer_inc[15:0];
                  end
               end
            end
            OP_WRITE: begin
               mem_we = (waddr_ext < MAX_PAYLOAD_BYTES);
            end
            OP_START: begin
               tone_on_in  = 1'b0;
               byte_ptr_in = '0;
               bit_ptr_in  = '0;
               timer_in    = '0;
               pre_left_in = pre_ticks_ff;
               pre_in      = (pre_ticks_ff != '0);
               parity_in   = 1'b1;
               busy_in     = 1'b1;
            end
            OP_STOP: begin
               if (busy_ff) begin
                  busy_in    = 1'b0;
                  pre_in     = 1'b0;
                  tone_on_in = 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   assign waddr_ext = {24'd0, req_payload.write_addr};
   assign raddr_ext = {23'd0, byte_ptr_in};
   assign mem_waddr = waddr_ext[AW-1:0];
   assign mem_raddr = (raddr_ext < MAX_PAYLOAD_BYTES) ? raddr_ext[AW-1:0] : '0;

   always_ff @(posedge clock) begin
      if (mem_we)
         payload_mem[mem_waddr] <= req_payload.write_data;
      if (mem_we && mem_waddr == mem_raddr)
         rd_data_ff <= req_payload.write_data;
      else
         rd_data_ff <= payload_mem[mem_raddr];
      if (mem_we && mem_waddr == '0)
         byte0_ff <= req_payload.write_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pre_ff       <= 1'b0;
         pre_left_ff  <= '0;
         parity_ff    <= 1'b0;
         timer_ff     <= '0;
         byte_ptr_ff  <= '0;
         bit_ptr_ff   <= '0;
         tone_on_ff   <= 1'b0;
         tone_freq_ff <= '0;
      end else begin
         busy_ff      <= busy_in;
         pre_ff       <= pre_in;
         pre_left_ff  <= pre_left_in;
         parity_ff    <= parity_in;
         timer_ff     <= timer_in;
         byte_ptr_ff  <= byte_ptr_in;
         bit_ptr_ff   <= bit_ptr_in;
         tone_on_ff   <= tone_on_in;
         tone_freq_ff <= tone_freq_in;
      end
   end

   always_comb begin
      rsp_payload_in.tone_on          = tone_on_in;
      rsp_payload_in.tone_freq        = tone_on_in ? tone_freq_in : 16'd0;
      rsp_payload_in.symbol_strobe    = strobe;
      rsp_payload_in.tx_busy          = busy_in;
      rsp_payload_in.in_preamble_flag = pre_in;
      rsp_payload_in.byte_index       = byte_ptr_in;
      rsp_payload_in.bit_position     = bit_ptr_in;
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (accept)
         rsp_valid_ff <= 1'b1;
      else if (!rsp_stall)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (accept)
         rsp_payload_ff <= rsp_payload_in;
   end

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted request produced no response");

   a_tone_needs_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.tone_on) |-> rsp_payload.tx_busy)
      else $error("tone driven while idle");

   a_preamble_needs_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.in_preamble_flag) |-> rsp_payload.tx_busy)
      else $error("preamble flag set while idle");

   a_strobe_needs_tone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.symbol_strobe) |-> rsp_payload.tone_on)
      else $error("symbol strobe without tone");

endmodule
